// ----- design/ltm_pkg.sv -----
`timescale 1ns / 1ps

package ltm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int TRI_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
  localparam int IDX_W     = $clog2(TRI_DEPTH);
  localparam int ROW_W     = $clog2(MAX_DIM);

  localparam int FLD_W     = 3;
  localparam int MODE_W    = 3;
  localparam int DIM_W     = 4;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  localparam int PROD_W    = 2 * DATA_W;
  localparam int TERM_W    = PROD_W - FRAC_W;
  localparam int ACC_W     = TERM_W + $clog2(MAX_DIM);

  // determinant steps feed back through the whole pipe
  localparam int DET_GAP   = 4;
  localparam int GAP_W     = $clog2(DET_GAP);

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_W;
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

  typedef enum logic [MODE_W-1:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_ADD    = 3'd2,
    OP_SUB    = 3'd3,
    OP_SCALE  = 3'd4,
    OP_MUL    = 3'd5,
    OP_DET    = 3'd6
  } ltm_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ltm_state_t;

  typedef struct packed {
    ltm_op_t          op;
    logic             first;
    logic             elast;
    logic             emit;
    logic             rlast;
    logic             start;
    logic [FLD_W-1:0] row;
    logic [FLD_W-1:0] col;
  } ltm_tag_t;

  typedef struct packed {
    logic             v;
    ltm_tag_t         tag;
    logic             a_ok;
    logic             b_ok;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
  } ltm_issue_t;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ltm_wr_t;

  // packed row start: r*(r+1)/2
  function automatic logic [IDX_W-1:0] tri_base(input logic [ROW_W-1:0] r);
    logic [31:0] p;
    p = 32'(r) * (32'(r) + 32'd1);
    return IDX_W'(p >> 1);
  endfunction

endpackage

// ----- design/lower_triangular_matrix_engine.sv -----
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       tuser: mode; tdata: row, col, value
// m_       out  m_tvalid / m_tready       tdata: out_row, out_col, result;
//                                         tuser: overflow; tlast: last
// cfg_     in   cfg_wen                   cfg_wdata: dimension
//
// loads write the store directly; add, subtract and scale issue one pass per element
// multiply issues n(n+1)(n+2)/6 product terms (120 at n = 8): one read
// of each store and one pass through the shared multiplier per product term
// determinant issues one step per diagonal element, each step waits on the previous one
// through the four-stage pipe; reset clears both stores at once through valid bits
// a result waiting in the output register freezes the whole pipe
`timescale 1ns / 1ps

module lower_triangular_matrix_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // row, col, value, zero pad
  input  logic [ltm_pkg::S_TDATA_W-1:0]   s_tdata,
  // mode
  input  logic [ltm_pkg::MODE_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_row, out_col, result, zero pad
  output logic [ltm_pkg::M_TDATA_W-1:0]   m_tdata,
  // overflow
  output logic [0:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_wen,
  input  logic [ltm_pkg::DIM_W-1:0]       cfg_wdata
);

  ltm_pkg::ltm_issue_t                  iss;
  ltm_pkg::ltm_wr_t                     wr;
  logic signed [ltm_pkg::DATA_W-1:0]    scalar;
  logic                                 adv, busy;
  logic [ltm_pkg::DATA_W-1:0]           a_rdata, b_rdata;

  ltm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .busy      (busy),
    .iss       (iss),
    .wr        (wr),
    .scalar    (scalar)
  );

  ltm_ram #(
    .WIDTH (ltm_pkg::DATA_W),
    .DEPTH (ltm_pkg::TRI_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr.we_a),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (adv),
    .raddr (iss.addr_a),
    .rdata (a_rdata)
  );

  ltm_ram #(
    .WIDTH (ltm_pkg::DATA_W),
    .DEPTH (ltm_pkg::TRI_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr.we_b),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (adv),
    .raddr (iss.addr_b),
    .rdata (b_rdata)
  );

  ltm_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .iss      (iss),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .scalar   (scalar),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .adv      (adv),
    .busy     (busy)
  );

endmodule

// ----- design/ltm_ram.sv -----
`timescale 1ns / 1ps

module ltm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/ltm_seq.sv -----
`timescale 1ns / 1ps

module ltm_seq (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [ltm_pkg::S_TDATA_W-1:0]            s_tdata,
  input  logic [ltm_pkg::MODE_W-1:0]               s_tuser,
  input  logic                                     cfg_wen,
  input  logic [ltm_pkg::DIM_W-1:0]                cfg_wdata,
  input  logic                                     adv,
  input  logic                                     busy,
  output ltm_pkg::ltm_issue_t                      iss,
  output ltm_pkg::ltm_wr_t                         wr,
  output logic signed [ltm_pkg::DATA_W-1:0]        scalar
);

  ltm_pkg::ltm_state_t              state, state_next;
  ltm_pkg::ltm_op_t                 op;
  logic [ltm_pkg::DIM_W-1:0]        dimension;
  logic [ltm_pkg::ROW_W-1:0]        ci, cj, ck, n_last;
  logic [ltm_pkg::GAP_W-1:0]        gap;
  logic [ltm_pkg::TRI_DEPTH-1:0]    a_valid, b_valid;

  logic                             accept;
  ltm_pkg::ltm_op_t                 in_mode;
  logic [ltm_pkg::FLD_W-1:0]        in_row, in_col;
  logic [ltm_pkg::DATA_W-1:0]       in_value;
  logic                             in_compute, ld_ok, run_end;

  assign in_mode  = ltm_pkg::ltm_op_t'(s_tuser);
  assign in_row   = s_tdata[ltm_pkg::FLD_W-1:0];
  assign in_col   = s_tdata[2*ltm_pkg::FLD_W-1:ltm_pkg::FLD_W];
  assign in_value = s_tdata[2*ltm_pkg::FLD_W+ltm_pkg::DATA_W-1:2*ltm_pkg::FLD_W];
  assign accept   = s_tvalid && s_tready;

  assign in_compute = (in_mode == ltm_pkg::OP_ADD) || (in_mode == ltm_pkg::OP_SUB) ||
                      (in_mode == ltm_pkg::OP_SCALE) || (in_mode == ltm_pkg::OP_MUL) ||
                      (in_mode == ltm_pkg::OP_DET);
  // elements above the diagonal or outside the store are dropped
  assign ld_ok = (32'(in_row) < ltm_pkg::MAX_DIM) && (in_col <= in_row);

  always_comb begin
    if (dimension == '0) begin
      n_last = '0;
    end else if (32'(dimension) > ltm_pkg::MAX_DIM) begin
      n_last = ltm_pkg::ROW_W'(ltm_pkg::MAX_DIM - 1);
    end else begin
      n_last = ltm_pkg::ROW_W'(dimension - ltm_pkg::DIM_W'(1));
    end
  end

  assign run_end = (cj == ci) && (ci == n_last);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ltm_pkg::ST_IDLE: begin
        if (accept && in_compute) begin
          state_next = ltm_pkg::ST_RUN;
        end
      end
      ltm_pkg::ST_RUN: begin
        if (adv && iss.v && iss.tag.rlast) begin
          state_next = ltm_pkg::ST_IDLE;
        end
      end
      default: state_next = ltm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ltm_pkg::ST_IDLE) && !busy;

    wr.we_a = accept && (in_mode == ltm_pkg::OP_LOAD_A) && ld_ok;
    wr.we_b = accept && (in_mode == ltm_pkg::OP_LOAD_B) && ld_ok;
    wr.addr = ltm_pkg::tri_base(ltm_pkg::ROW_W'(in_row)) + ltm_pkg::IDX_W'(in_col);
    wr.data = in_value;

    iss           = '0;
    iss.tag.op    = op;
    iss.tag.start = 1'b0;
    case (op)
      ltm_pkg::OP_MUL: begin
        iss.addr_a    = ltm_pkg::tri_base(ci) + ltm_pkg::IDX_W'(ck);
        iss.addr_b    = ltm_pkg::tri_base(ck) + ltm_pkg::IDX_W'(cj);
        iss.tag.first = (ck == cj);
        iss.tag.elast = (ck == ci);
        iss.tag.emit  = (ck == ci);
        iss.tag.rlast = (ck == ci) && run_end;
        iss.tag.row   = ltm_pkg::FLD_W'(ci);
        iss.tag.col   = ltm_pkg::FLD_W'(cj);
      end
      ltm_pkg::OP_DET: begin
        iss.addr_a    = ltm_pkg::tri_base(ci) + ltm_pkg::IDX_W'(ci);
        iss.addr_b    = iss.addr_a;
        iss.tag.first = 1'b1;
        iss.tag.elast = 1'b1;
        iss.tag.emit  = (ci == n_last);
        iss.tag.rlast = (ci == n_last);
        iss.tag.start = (ci == '0);
        iss.tag.row   = '0;
        iss.tag.col   = '0;
      end
      default: begin
        iss.addr_a    = ltm_pkg::tri_base(ci) + ltm_pkg::IDX_W'(cj);
        iss.addr_b    = iss.addr_a;
        iss.tag.first = 1'b1;
        iss.tag.elast = 1'b1;
        iss.tag.emit  = 1'b1;
        iss.tag.rlast = run_end;
        iss.tag.row   = ltm_pkg::FLD_W'(ci);
        iss.tag.col   = ltm_pkg::FLD_W'(cj);
      end
    endcase
    iss.v    = (state == ltm_pkg::ST_RUN) && ((op != ltm_pkg::OP_DET) || (gap == '0));
    iss.a_ok = a_valid[iss.addr_a];
    iss.b_ok = b_valid[iss.addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ltm_pkg::ST_IDLE;
      dimension <= ltm_pkg::DIM_RESET;
      a_valid   <= '0;
      b_valid   <= '0;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
      gap       <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        dimension <= cfg_wdata;
      end
      if (wr.we_a) begin
        a_valid[wr.addr] <= 1'b1;
      end
      if (wr.we_b) begin
        b_valid[wr.addr] <= 1'b1;
      end
      if (accept && in_compute) begin
        ci  <= '0;
        cj  <= '0;
        ck  <= '0;
        gap <= '0;
      end else if ((state == ltm_pkg::ST_RUN) && adv) begin
        if (op == ltm_pkg::OP_DET) begin
          gap <= gap + 1'b1;
          if (iss.v) begin
            ci <= ci + 1'b1;
          end
        end else if (iss.v) begin
          // k walks j..i for multiply, then next column, then next row
          if ((op == ltm_pkg::OP_MUL) && (ck != ci)) begin
            ck <= ck + 1'b1;
          end else if (cj != ci) begin
            cj <= cj + 1'b1;
            ck <= cj + 1'b1;
          end else begin
            ci <= ci + 1'b1;
            cj <= '0;
            ck <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_compute) begin
      op     <= in_mode;
      scalar <= in_value;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (state == ltm_pkg::ST_RUN) |-> !(wr.we_a || wr.we_b))
    else $error("store written during a run");

  assert property (@(posedge clk) disable iff (rst)
    (iss.v && (iss.tag.op == ltm_pkg::OP_DET) && adv) |=> !iss.v)
    else $error("determinant steps issued too close");
`endif

endmodule

// ----- design/ltm_alu.sv -----
`timescale 1ns / 1ps

module ltm_alu (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ltm_pkg::ltm_issue_t                  iss,
  input  logic [ltm_pkg::DATA_W-1:0]           a_rdata,
  input  logic [ltm_pkg::DATA_W-1:0]           b_rdata,
  input  logic signed [ltm_pkg::DATA_W-1:0]    scalar,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [ltm_pkg::M_TDATA_W-1:0]        m_tdata,
  output logic [0:0]                           m_tuser,
  output logic                                 m_tlast,
  output logic                                 adv,
  output logic                                 busy
);

  logic                                 s1_v, s2_v, s3_v, s4_v;
  ltm_pkg::ltm_tag_t                    s1_tag, s2_tag, s3_tag, s4_tag;
  logic                                 s1_aok, s1_bok;
  logic signed [ltm_pkg::PROD_W-1:0]    s2_val;
  logic                                 s2_rnd;
  logic signed [ltm_pkg::TERM_W-1:0]    s3_term;
  logic signed [ltm_pkg::ACC_W-1:0]     s4_acc;
  logic signed [ltm_pkg::DATA_W-1:0]    det_reg;
  logic                                 det_ovf;

  logic signed [ltm_pkg::DATA_W-1:0]    a_op, b_op, x, y;
  logic signed [ltm_pkg::PROD_W-1:0]    prod;
  logic signed [ltm_pkg::DATA_W:0]      sum;
  logic                                 rnd;
  logic signed [ltm_pkg::PROD_W-1:0]    s2_val_next;
  logic signed [ltm_pkg::TERM_W-1:0]    s3_term_next;
  logic signed [ltm_pkg::ACC_W-1:0]     s4_acc_next;
  logic                                 sat_ovf, det_ovf_next, out_load, m_tvalid_next;
  logic signed [ltm_pkg::DATA_W-1:0]    sat_val;

  logic [ltm_pkg::FLD_W-1:0]            out_row, out_col;
  logic [ltm_pkg::DATA_W-1:0]           result;
  logic                                 overflow, last;

  assign adv  = !m_tvalid || m_tready;
  assign busy = s1_v || s2_v || s3_v || s4_v;

  // stage 1: operand select, one multiply or one add or subtract
  always_comb begin
    a_op = s1_aok ? a_rdata : '0;
    b_op = s1_bok ? b_rdata : '0;
    case (s1_tag.op)
      ltm_pkg::OP_MUL: begin
        x   = a_op;
        y   = b_op;
        rnd = 1'b1;
      end
      ltm_pkg::OP_SCALE: begin
        x   = a_op;
        y   = scalar;
        rnd = 1'b1;
      end
      ltm_pkg::OP_DET: begin
        x   = s1_tag.start ? ltm_pkg::Q_ONE : det_reg;
        y   = a_op;
        rnd = 1'b1;
      end
      default: begin
        x   = a_op;
        y   = b_op;
        rnd = 1'b0;
      end
    endcase
    prod = x * y;
    if (s1_tag.op == ltm_pkg::OP_SUB) begin
      sum = (ltm_pkg::DATA_W+1)'(a_op) - (ltm_pkg::DATA_W+1)'(b_op);
    end else begin
      sum = (ltm_pkg::DATA_W+1)'(a_op) + (ltm_pkg::DATA_W+1)'(b_op);
    end
    s2_val_next = rnd ? prod : ltm_pkg::PROD_W'(sum);
  end

  // stage 2: round products half up back to q16.16; sums pass unchanged
  always_comb begin
    if (s2_rnd) begin
      s3_term_next = ltm_pkg::TERM_W'((s2_val + ltm_pkg::RND_HALF) >>> ltm_pkg::FRAC_W);
    end else begin
      s3_term_next = ltm_pkg::TERM_W'(s2_val);
    end
  end

  // stage 3: accumulate
  assign s4_acc_next = s3_tag.first ? ltm_pkg::ACC_W'(s3_term)
                                    : s4_acc + ltm_pkg::ACC_W'(s3_term);

  // stage 4: saturate
  always_comb begin
    sat_ovf = !((&s4_acc[ltm_pkg::ACC_W-1:ltm_pkg::DATA_W-1]) ||
                !(|s4_acc[ltm_pkg::ACC_W-1:ltm_pkg::DATA_W-1]));
    if (sat_ovf) begin
      sat_val = s4_acc[ltm_pkg::ACC_W-1] ? ltm_pkg::Q_MIN : ltm_pkg::Q_MAX;
    end else begin
      sat_val = s4_acc[ltm_pkg::DATA_W-1:0];
    end
    det_ovf_next  = sat_ovf || (!s4_tag.start && det_ovf);
    out_load      = adv && s4_v && s4_tag.emit;
    m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      s4_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (adv) begin
        s1_v <= iss.v;
        s2_v <= s1_v;
        s3_v <= s2_v;
        s4_v <= s3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag  <= iss.tag;
      s1_aok  <= iss.a_ok;
      s1_bok  <= iss.b_ok;
      s2_tag  <= s1_tag;
      s2_val  <= s2_val_next;
      s2_rnd  <= rnd;
      s3_tag  <= s2_tag;
      s3_term <= s3_term_next;
      if (s3_v) begin
        s4_tag <= s3_tag;
        s4_acc <= s4_acc_next;
      end
      if (s4_v && (s4_tag.op == ltm_pkg::OP_DET)) begin
        det_reg <= sat_val;
        det_ovf <= det_ovf_next;
      end
    end
    if (out_load) begin
      out_row  <= s4_tag.row;
      out_col  <= s4_tag.col;
      result   <= sat_val;
      overflow <= (s4_tag.op == ltm_pkg::OP_DET) ? det_ovf_next : sat_ovf;
      last     <= s4_tag.rlast;
    end
  end

  assign m_tdata = {{(ltm_pkg::M_TDATA_W - 2*ltm_pkg::FLD_W - ltm_pkg::DATA_W){1'b0}},
                    result, out_col, out_row};
  assign m_tuser = overflow;
  assign m_tlast = last;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({s1_v, s2_v, s3_v, s4_v}))
    else $error("pipe moved while output stalled");

  assert property (@(posedge clk) disable iff (rst)
    (s4_v && (s4_tag.op == ltm_pkg::OP_DET)) |-> (!s3_v && !s2_v))
    else $error("determinant step overlaps the next one");

  assert property (@(posedge clk) disable iff (rst)
    (s1_v && (s1_tag.op == ltm_pkg::OP_MUL) && !s1_tag.first) |-> s2_v)
    else $error("gap inside a dot product");
`endif

endmodule
